// File: src/rpa_pkg.sv
// rpa_pkg: shared types, constants and codes of the path attenuation unit
// depends on nothing; imported by every module of the block but rpa_checker
package rpa_pkg;

  // configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ZK_COEF     = 3'd0,
    REG_ZK_EXP      = 3'd1,
    REG_PIA_LIMIT   = 3'd2,
    REG_RANGE_OVR   = 3'd3,
    REG_BIN_SPACING = 3'd4
  } cfg_reg_t;

  localparam logic [23:0] ZK_COEF_RST     = 24'd734000;
  localparam logic [13:0] ZK_EXP_RST      = 14'd5505;
  localparam logic [14:0] PIA_LIMIT_RST   = 15'd2560;
  localparam logic [15:0] RANGE_OVR_RST   = 16'd0;
  localparam logic [15:0] BIN_SPACING_RST = 16'd500;

  // fixed-point constants
  localparam logic [22:0] LOG2_10_TENTH   = 23'd5573271;    // log2(10)/10, Q0.24
  localparam logic [30:0] TENTH_LN10_Q32  = 31'd1977905534; // 0.2*ln(10), Q0.32
  localparam logic [25:0] TEN_LOG10_2_Q24 = 26'd50504453;   // 10*log10(2), Q2.24
  localparam logic signed [44:0] E_SAT    = 45'sd201326592; // 12.0 in Q.24

  // shared divider
  localparam int DivNW   = 52;
  localparam int DivDW   = 32;
  localparam int DivCntW = 6;

  // table of 2^(2^-i), i = 1..24, filled after reset
  localparam int TabLen  = 24;
  localparam int TabIdxW = 5;
  localparam int CntW    = 5;

  localparam logic [CntW-1:0]    SQ_LAST  = CntW'(30);  // 31 root digits
  localparam logic [CntW-1:0]    LG_LAST  = CntW'(23);  // 24 squaring steps
  localparam logic [CntW-1:0]    POW_LAST = CntW'(TabLen - 1);
  localparam logic [TabIdxW-1:0] TAB_LAST = TabIdxW'(TabLen - 1);

  typedef enum logic [4:0] {
    OP_NONE,
    OP_TAB_INIT,
    OP_SQ_LOAD,
    OP_SQ_STEP,
    OP_SQ_STORE,
    OP_LATCH,
    OP_DIV_FACTOR,
    OP_FAC_SAVE,
    OP_CALC_A,
    OP_LG_NORM,
    OP_LG_PREP,
    OP_LG_SQ,
    OP_NUM,
    OP_DIV_E,
    OP_E_SAVE,
    OP_POW_STEP,
    OP_K_SUM,
    OP_PROD,
    OP_DIV_CLAMP,
    OP_CLAMP_SAVE,
    OP_X_LOAD,
    OP_NL_T,
    OP_PIA,
    OP_OUT_LOAD
  } op_t;

  typedef enum logic [4:0] {
    ST_TAB_INIT,
    ST_SQ_LOAD,
    ST_SQ_STEP,
    ST_SQ_STORE,
    ST_IDLE,
    ST_BRANCH,
    ST_FAC_WAIT,
    ST_A,
    ST_LG_NORM,
    ST_LG_SQ,
    ST_NUM,
    ST_E_START,
    ST_E_WAIT,
    ST_POW,
    ST_K,
    ST_PROD,
    ST_CLAMP_CHK,
    ST_CLAMP_WAIT,
    ST_X,
    ST_NL,
    ST_PIA,
    ST_OUT
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [TabIdxW-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic lg_top;
    logic prod_big;
    logic is_data;
  } dp_stat_t;

endpackage

// File: src/radar_path_attenuation_unit.sv
// radar_path_attenuation_unit: path-integrated attenuation along radar rays
// depends on rpa_pkg, rpa_ctrl, rpa_datapath (with rpa_div)
//
// Usage:
//   Input channel in_valid/in_ready carries one range bin per request:
//   reflectivity (dBZ, signed Q8.8), is_data and ray_start. Output channel
//   out_valid/out_ready returns one attenuation value (dB, Q7.8) per bin.
//   Configuration is to be written through cfg_we/cfg_index/cfg_data only
//   while idle; the block itself does not enforce this. One bin is in work
//   at a time. A bin that is not data passes the branch state straight to
//   the output state. A data bin takes two passes of the shared divider (a
//   third pass plus a second product when the sum reaches its limit and is
//   pulled back), two log2 passes of normalize steps plus 24 squaring
//   steps, and 24 steps of the power table multiply. After reset the
//   2^(2^-i) table is built by a root extractor: 24 roots, each a load,
//   the root digit steps and a store, with in_ready low; configuration
//   writes are taken throughout. Reset also clears the sum and held value.
//   The result sits in an output register; the next bin is accepted while
//   it waits, and a bin finished while the receiver stalls holds until the
//   register frees.
module radar_path_attenuation_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [15:0]           reflectivity,
  input  logic                         is_data,
  input  logic                         ray_start,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [14:0]                  attenuation,
  input  logic                         cfg_we,
  input  logic [rpa_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [rpa_pkg::CfgDataW-1:0] cfg_data
);
  import rpa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rpa_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .reflectivity (reflectivity),
    .is_data      (is_data),
    .ray_start    (ray_start),
    .cmd          (cmd),
    .stat         (stat),
    .attenuation  (attenuation)
  );

endmodule

// File: src/rpa_div.sv
// rpa_div: radix-2 restoring divider, one quotient bit per cycle
// depends on rpa_pkg
module rpa_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rpa_pkg::DivNW-1:0] dividend,
  input  logic [rpa_pkg::DivDW-1:0] divisor,
  output logic                      busy,
  output logic [rpa_pkg::DivNW-1:0] quotient
);
  import rpa_pkg::*;

  localparam logic [DivCntW-1:0] DIV_LAST = DivCntW'(DivNW - 1);

  logic [DivDW-1:0]   dsr;
  logic [DivDW-1:0]   rem;
  logic [DivCntW-1:0] cnt;
  logic [DivDW:0]     rem_sh;
  logic [DivDW:0]     diff;

  assign rem_sh = {rem, quotient[DivNW-1]};
  assign diff   = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      // no borrow means the divisor fits
      if (!diff[DivDW]) begin
        rem      <= diff[DivDW-1:0];
        quotient <= {quotient[DivNW-2:0], 1'b1};
      end else begin
        rem      <= rem_sh[DivDW-1:0];
        quotient <= {quotient[DivNW-2:0], 1'b0};
      end
    end
  end

endmodule

// File: src/rpa_datapath.sv
// rpa_datapath: configuration registers, running sum, log2 / pow2 / root steps
// depends on rpa_pkg and rpa_div; driven one command per cycle by rpa_ctrl
module rpa_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [rpa_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [rpa_pkg::CfgDataW-1:0] cfg_data,
  input  logic signed [15:0]           reflectivity,
  input  logic                         is_data,
  input  logic                         ray_start,
  input  rpa_pkg::dp_cmd_t             cmd,
  output rpa_pkg::dp_stat_t            stat,
  output logic [14:0]                  attenuation
);
  import rpa_pkg::*;

  // configuration
  logic [23:0] zk_coef;
  logic [13:0] zk_exp;
  logic [14:0] pia_limit;
  logic [15:0] range_ovr;
  logic [15:0] bin_spacing;

  // ray state
  logic [31:0] k_sum;
  logic [14:0] held;

  // current request
  logic signed [15:0] refl;
  logic               item_data;

  // power table and its root extractor
  logic [30:0] tab [TabLen];
  logic [31:0] tab_prev;
  logic [61:0] sq_rad;
  logic [33:0] sq_rem;
  logic [30:0] sq_root;
  logic [35:0] sq_shift;
  logic [35:0] sq_trial;

  // working registers
  logic [31:0]        factor;
  logic signed [31:0] a_val;
  logic [31:0]        num_mag;
  logic               num_neg;
  logic [32:0]        lg_y;
  logic [5:0]         lg_n;
  logic [30:0]        lg_m;
  logic [23:0]        lg_frac;
  logic signed [44:0] e_val;
  logic [31:0]        pm;
  logic [23:0]        pow_f;
  logic [31:0]        s_val;
  logic [63:0]        prod;
  logic [31:0]        t_val;

  // divider
  logic              div_start;
  logic [DivNW-1:0]  div_dividend;
  logic [DivDW-1:0]  div_divisor;
  logic              div_busy;
  logic [DivNW-1:0]  div_quot;

  // combinational terms
  logic [13:0]        d_eff;
  logic [23:0]        c_eff;
  logic [15:0]        fac_num;
  logic [9:0]         fac_den;
  logic [46:0]        fac_prod;
  logic [23:0]        fac_div;
  logic signed [39:0] a_prod;
  logic signed [39:0] a_round;
  logic signed [31:0] num_s;
  logic signed [44:0] e_next;
  logic [62:0]        pow_prod;
  logic signed [20:0] e_ip;
  logic signed [21:0] e_sh;
  logic [31:0]        k_val;
  logic [32:0]        sum33;
  logic [61:0]        sq_prod;
  logic [31:0]        sq_hi;
  logic [29:0]        lg_val;
  logic [29:0]        nl;
  logic [43:0]        nl_prod;
  logic [57:0]        pia_prod;
  logic [17:0]        pia_val;

  assign d_eff    = (zk_exp == '0) ? 14'd1 : zk_exp;
  assign c_eff    = (zk_coef == '0) ? 24'd1 : zk_coef;
  assign fac_num  = (range_ovr != '0) ? range_ovr : bin_spacing;
  assign fac_den  = (range_ovr != '0) ? 10'd256 : 10'd1000;
  assign fac_prod = 47'(fac_num) * 47'(TENTH_LN10_Q32);
  assign fac_div  = 24'(fac_den) * 24'(d_eff);

  // reflectivity times log2(10)/10, divided by 256 toward zero
  assign a_prod  = 40'(refl) * 40'sd5573271;
  assign a_round = a_prod + (a_prod[39] ? 40'sd255 : 40'sd0);

  assign lg_val = {lg_n, lg_frac};
  assign num_s  = a_val - $signed({2'b00, lg_val});

  assign e_next = num_neg ? -$signed({1'b0, div_quot[43:0]})
                          :  $signed({1'b0, div_quot[43:0]});

  assign pow_prod = 63'(pm) * 63'(tab[cmd.idx]);

  // scale 2^frac by the integer part of the exponent
  assign e_ip = e_val[44:24];
  assign e_sh = 22'sd10 - 22'(e_ip);

  always_comb begin
    if (e_val >= E_SAT) begin
      k_val = '1;
    end else if (e_sh < 0) begin
      k_val = {pm[30:0], 1'b0};
    end else if (e_sh >= 22'sd31) begin
      k_val = '0;
    end else begin
      k_val = pm >> e_sh[4:0];
    end
  end

  assign sum33 = {1'b0, k_sum} + {1'b0, k_val};

  assign sq_prod = 62'(lg_m) * 62'(lg_m);
  assign sq_hi   = sq_prod[61:30];

  assign sq_shift = {sq_rem, sq_rad[61:60]};
  assign sq_trial = {3'b000, sq_root, 2'b01};

  assign nl       = 30'h2000_0000 - lg_val;
  assign nl_prod  = 44'(nl) * 44'(zk_exp);
  assign pia_prod = 58'(t_val) * 58'(TEN_LOG10_2_Q24);
  assign pia_val  = pia_prod[57:40];

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (cmd.op)
      OP_DIV_FACTOR: begin
        div_start    = 1'b1;
        div_dividend = {1'b0, fac_prod, 4'b0000};
        div_divisor  = {8'd0, fac_div};
      end
      OP_DIV_E: begin
        div_start    = 1'b1;
        div_dividend = {8'd0, num_mag, 12'd0};
        div_divisor  = {18'd0, d_eff};
      end
      OP_DIV_CLAMP: begin
        div_start    = 1'b1;
        div_dividend = {8'd0, {44{1'b1}}};
        div_divisor  = factor;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  rpa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  assign stat.div_busy = div_busy;
  assign stat.lg_top   = lg_y[32];
  assign stat.prod_big = |prod[63:44];
  assign stat.is_data  = item_data;

  // configuration and ray state
  always_ff @(posedge clk) begin
    if (rst) begin
      zk_coef     <= ZK_COEF_RST;
      zk_exp      <= ZK_EXP_RST;
      pia_limit   <= PIA_LIMIT_RST;
      range_ovr   <= RANGE_OVR_RST;
      bin_spacing <= BIN_SPACING_RST;
      k_sum       <= '0;
      held        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ZK_COEF:     zk_coef     <= cfg_data[23:0];
          REG_ZK_EXP:      zk_exp      <= cfg_data[13:0];
          REG_PIA_LIMIT:   pia_limit   <= cfg_data[14:0];
          REG_RANGE_OVR:   range_ovr   <= cfg_data[15:0];
          REG_BIN_SPACING: bin_spacing <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
      case (cmd.op)
        OP_LATCH: begin
          if (ray_start) begin
            k_sum <= '0;
            held  <= '0;
          end
        end
        OP_X_LOAD: k_sum <= s_val;
        OP_PIA: begin
          held <= (pia_val > {3'b000, pia_limit}) ? pia_limit : pia_val[14:0];
        end
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_TAB_INIT: tab_prev <= 32'h8000_0000;
      OP_SQ_LOAD: begin
        sq_rad  <= {tab_prev, 30'd0};
        sq_rem  <= '0;
        sq_root <= '0;
      end
      OP_SQ_STEP: begin
        sq_rad <= {sq_rad[59:0], 2'b00};
        if (sq_shift >= sq_trial) begin
          sq_rem  <= 34'(sq_shift - sq_trial);
          sq_root <= {sq_root[29:0], 1'b1};
        end else begin
          sq_rem  <= sq_shift[33:0];
          sq_root <= {sq_root[29:0], 1'b0};
        end
      end
      OP_SQ_STORE: begin
        tab[cmd.idx] <= sq_root;
        tab_prev     <= {1'b0, sq_root};
      end
      OP_LATCH: begin
        refl      <= reflectivity;
        item_data <= is_data;
      end
      OP_FAC_SAVE: factor <= (|div_quot[51:32]) ? '1 : div_quot[31:0];
      OP_CALC_A: begin
        a_val <= a_round[39:8];
        lg_y  <= {9'd0, c_eff};
        lg_n  <= 6'd32;
      end
      OP_LG_NORM: begin
        lg_y <= {lg_y[31:0], 1'b0};
        lg_n <= lg_n - 1'b1;
      end
      OP_LG_PREP: begin
        lg_m    <= lg_y[32:2];
        lg_frac <= '0;
      end
      OP_LG_SQ: begin
        lg_m    <= sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
        lg_frac <= {lg_frac[22:0], sq_hi[31]};
      end
      OP_NUM: begin
        num_neg <= num_s[31];
        num_mag <= num_s[31] ? 32'(-num_s) : 32'(num_s);
      end
      OP_E_SAVE: begin
        e_val <= e_next;
        pow_f <= e_next[23:0];
        pm    <= 32'h4000_0000;
      end
      OP_POW_STEP: begin
        if (pow_f[23]) begin
          pm <= pow_prod[61:30];
        end
        pow_f <= {pow_f[22:0], 1'b0};
      end
      OP_K_SUM:      s_val <= sum33[32] ? '1 : sum33[31:0];
      OP_PROD:       prod  <= 64'(factor) * 64'(s_val);
      OP_CLAMP_SAVE: s_val <= div_quot[31:0];
      OP_X_LOAD: begin
        lg_y <= 33'h1_0000_0000 - {1'b0, prod[43:12]};
        lg_n <= 6'd32;
      end
      OP_NL_T:     t_val       <= nl_prod[43:12];
      OP_OUT_LOAD: attenuation <= held;
      default: begin
      end
    endcase
  end

endmodule

// File: src/rpa_ctrl.sv
// rpa_ctrl: sequencer of the attenuation unit, request handshakes
// depends on rpa_pkg; issues one datapath command per cycle
module rpa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rpa_pkg::dp_stat_t stat,
  output rpa_pkg::dp_cmd_t  cmd
);
  import rpa_pkg::*;

  state_t             state, state_next;
  logic [CntW-1:0]    cnt, cnt_next;
  logic [TabIdxW-1:0] tidx, tidx_next;
  logic               lg_pass, lg_pass_next;
  logic               out_valid_next;
  logic               out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_TAB_INIT;
      cnt       <= '0;
      tidx      <= '0;
      lg_pass   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      tidx      <= tidx_next;
      lg_pass   <= lg_pass_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    tidx_next      = tidx;
    lg_pass_next   = lg_pass;
    cmd.op         = OP_NONE;
    cmd.idx        = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;

    case (state)
      ST_TAB_INIT: begin
        cmd.op     = OP_TAB_INIT;
        tidx_next  = '0;
        state_next = ST_SQ_LOAD;
      end
      ST_SQ_LOAD: begin
        cmd.op     = OP_SQ_LOAD;
        cnt_next   = '0;
        state_next = ST_SQ_STEP;
      end
      ST_SQ_STEP: begin
        cmd.op   = OP_SQ_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == SQ_LAST) begin
          state_next = ST_SQ_STORE;
        end
      end
      ST_SQ_STORE: begin
        cmd.op  = OP_SQ_STORE;
        cmd.idx = tidx;
        if (tidx == TAB_LAST) begin
          state_next = ST_IDLE;
        end else begin
          tidx_next  = tidx + 1'b1;
          state_next = ST_SQ_LOAD;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LATCH;
          state_next = ST_BRANCH;
        end
      end
      ST_BRANCH: begin
        if (stat.is_data) begin
          cmd.op     = OP_DIV_FACTOR;
          state_next = ST_FAC_WAIT;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_FAC_WAIT: begin
        if (!stat.div_busy) begin
          cmd.op     = OP_FAC_SAVE;
          state_next = ST_A;
        end
      end
      ST_A: begin
        cmd.op       = OP_CALC_A;
        lg_pass_next = 1'b0;
        state_next   = ST_LG_NORM;
      end
      ST_LG_NORM: begin
        if (stat.lg_top) begin
          cmd.op     = OP_LG_PREP;
          cnt_next   = '0;
          state_next = ST_LG_SQ;
        end else begin
          cmd.op = OP_LG_NORM;
        end
      end
      ST_LG_SQ: begin
        cmd.op   = OP_LG_SQ;
        cnt_next = cnt + 1'b1;
        if (cnt == LG_LAST) begin
          state_next = lg_pass ? ST_NL : ST_NUM;
        end
      end
      ST_NUM: begin
        cmd.op     = OP_NUM;
        state_next = ST_E_START;
      end
      ST_E_START: begin
        cmd.op     = OP_DIV_E;
        state_next = ST_E_WAIT;
      end
      ST_E_WAIT: begin
        if (!stat.div_busy) begin
          cmd.op     = OP_E_SAVE;
          cnt_next   = '0;
          state_next = ST_POW;
        end
      end
      ST_POW: begin
        cmd.op   = OP_POW_STEP;
        cmd.idx  = TabIdxW'(cnt);
        cnt_next = cnt + 1'b1;
        if (cnt == POW_LAST) begin
          state_next = ST_K;
        end
      end
      ST_K: begin
        cmd.op     = OP_K_SUM;
        state_next = ST_PROD;
      end
      ST_PROD: begin
        cmd.op     = OP_PROD;
        state_next = ST_CLAMP_CHK;
      end
      ST_CLAMP_CHK: begin
        // product at or above one: pull the sum back under the limit
        if (stat.prod_big) begin
          cmd.op     = OP_DIV_CLAMP;
          state_next = ST_CLAMP_WAIT;
        end else begin
          state_next = ST_X;
        end
      end
      ST_CLAMP_WAIT: begin
        if (!stat.div_busy) begin
          cmd.op     = OP_CLAMP_SAVE;
          state_next = ST_PROD;
        end
      end
      ST_X: begin
        cmd.op       = OP_X_LOAD;
        lg_pass_next = 1'b1;
        state_next   = ST_LG_NORM;
      end
      ST_NL: begin
        cmd.op     = OP_NL_T;
        state_next = ST_PIA;
      end
      ST_PIA: begin
        cmd.op     = OP_PIA;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.op         = OP_OUT_LOAD;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: src/rpa_checker.sv
// rpa_checker: port-level checks of the attenuation unit, bound to the top
// depends on radar_path_attenuation_unit ports only
module rpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [14:0] attenuation
);

  // requests accepted but not yet delivered
  logic [1:0] pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !in_ready && !out_valid)
    else $error("ports active right after reset");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in work");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pend != 2'd0)
    else $error("result without an accepted request");

  a_pend_bound: assert property (@(posedge clk) disable iff (rst) pend != 2'd3)
    else $error("more than two requests outstanding");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(attenuation))
    else $error("stalled result changed");

endmodule

bind radar_path_attenuation_unit rpa_checker u_rpa_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .attenuation (attenuation)
);
